// ===== hdl/silcd_pkg.sv =====
// ----------------------------------------------------------------------------
// silcd_pkg
// Shared types and character codes for the integer to nibble stream block.
// ----------------------------------------------------------------------------
package silcd_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hdl/silcd_front.sv =====
// ----------------------------------------------------------------------------
// silcd_front
// Accepts integers, splits them into a sign and an unsigned magnitude, and
// pushes the result into the queue.
// ----------------------------------------------------------------------------
module silcd_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [VALUE_BITS-1:0] value,
  input  silcd_pkg::q_stat_t     q_stat,
  output logic                   push,
  output logic                   push_neg,
  output logic [VALUE_BITS-1:0]  push_mag
);
  import silcd_pkg::*;

  logic [VALUE_BITS-1:0] raw;

  assign raw      = $unsigned(value);
  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;
  assign push_neg = raw[VALUE_BITS-1];
  assign push_mag = push_neg ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;

endmodule

// ===== hdl/silcd_queue.sv =====
// ----------------------------------------------------------------------------
// silcd_queue
// Two-entry queue of sign and magnitude pairs between front and back.
// ----------------------------------------------------------------------------
module silcd_queue #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  push_neg,
  input  logic [VALUE_BITS-1:0] push_mag,
  input  logic                  pop,
  output silcd_pkg::q_stat_t    q_stat,
  output logic                  head_neg,
  output logic [VALUE_BITS-1:0] head_mag
);
  import silcd_pkg::*;

  logic [VALUE_BITS:0] mem [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;

  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);
  assign head_neg     = mem[rd_ptr][VALUE_BITS];
  assign head_mag     = mem[rd_ptr][VALUE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= {push_neg, push_mag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/silcd_back.sv =====
// ----------------------------------------------------------------------------
// silcd_back
// Converts one magnitude to decimal by shift and add-three, skips leading
// zeros, and sends the characters out as high and low nibbles.
// ----------------------------------------------------------------------------
module silcd_back #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  silcd_pkg::q_stat_t    q_stat,
  input  logic                  head_neg,
  input  logic [VALUE_BITS-1:0] head_mag,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            nibble,
  output logic                  last
);
  import silcd_pkg::*;

  localparam int BCD_BITS = 4 * MAX_DIGITS;
  localparam int BIT_CW   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int DIG_CW   = $clog2(MAX_DIGITS + 1);
  localparam logic [BIT_CW-1:0] BIT_LAST = BIT_CW'(VALUE_BITS - 1);
  localparam logic [DIG_CW-1:0] DIG_ALL  = DIG_CW'(MAX_DIGITS);
  localparam logic [DIG_CW-1:0] DIG_ONE  = DIG_CW'(1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CONV    = 3'd1;
  localparam logic [2:0] S_SKIP    = 3'd2;
  localparam logic [2:0] S_SIGN_HI = 3'd3;
  localparam logic [2:0] S_SIGN_LO = 3'd4;
  localparam logic [2:0] S_DIG_HI  = 3'd5;
  localparam logic [2:0] S_DIG_LO  = 3'd6;

  logic [2:0]            state,     state_next;
  logic [BCD_BITS-1:0]   bcd,       bcd_next;
  logic [VALUE_BITS-1:0] shreg,     shreg_next;
  logic [BIT_CW-1:0]     bit_cnt,   bit_cnt_next;
  logic [DIG_CW-1:0]     dig_cnt,   dig_cnt_next;
  logic                  neg,       neg_next;
  logic                  ovf,       ovf_next;
  logic                  out_valid_next;
  logic [3:0]            nibble_next;
  logic                  last_next;
  logic [BCD_BITS-1:0]   adjusted;
  logic [3:0]            top_digit;
  logic                  out_free;

  assign top_digit = bcd[BCD_BITS-1 -: 4];
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    for (int d = 0; d < MAX_DIGITS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        adjusted[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end else begin
        adjusted[4*d +: 4] = bcd[4*d +: 4];
      end
    end
  end

  always_comb begin
    state_next     = state;
    bcd_next       = bcd;
    shreg_next     = shreg;
    bit_cnt_next   = bit_cnt;
    dig_cnt_next   = dig_cnt;
    neg_next       = neg;
    ovf_next       = ovf;
    out_valid_next = out_valid && !out_ready;
    nibble_next    = nibble;
    last_next      = last;
    pop            = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop          = 1'b1;
          neg_next     = head_neg;
          shreg_next   = head_mag;
          bcd_next     = '0;
          ovf_next     = 1'b0;
          bit_cnt_next = '0;
          state_next   = S_CONV;
        end
      end
      S_CONV: begin
        bcd_next     = {adjusted[BCD_BITS-2:0], shreg[VALUE_BITS-1]};
        ovf_next     = ovf || adjusted[BCD_BITS-1];
        shreg_next   = shreg << 1;
        bit_cnt_next = bit_cnt + BIT_CW'(1);
        if (bit_cnt == BIT_LAST) begin
          dig_cnt_next = DIG_ALL;
          state_next   = S_SKIP;
        end
      end
      S_SKIP: begin
        if (!ovf && (dig_cnt > DIG_ONE) && (top_digit == 4'd0)) begin
          bcd_next     = bcd << 4;
          dig_cnt_next = dig_cnt - DIG_ONE;
        end else begin
          state_next = neg ? S_SIGN_HI : S_DIG_HI;
        end
      end
      S_SIGN_HI: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          nibble_next    = CHAR_MINUS[7:4];
          last_next      = 1'b0;
          state_next     = S_SIGN_LO;
        end
      end
      S_SIGN_LO: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          nibble_next    = CHAR_MINUS[3:0];
          last_next      = 1'b0;
          state_next     = S_DIG_HI;
        end
      end
      S_DIG_HI: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          nibble_next    = CHAR_ZERO[7:4];
          last_next      = 1'b0;
          state_next     = S_DIG_LO;
        end
      end
      S_DIG_LO: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          nibble_next    = CHAR_ZERO[3:0] | top_digit;
          last_next      = (dig_cnt == DIG_ONE);
          if (dig_cnt == DIG_ONE) begin
            state_next = S_IDLE;
          end else begin
            bcd_next     = bcd << 4;
            dig_cnt_next = dig_cnt - DIG_ONE;
            state_next   = S_DIG_HI;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    bcd     <= bcd_next;
    shreg   <= shreg_next;
    bit_cnt <= bit_cnt_next;
    dig_cnt <= dig_cnt_next;
    neg     <= neg_next;
    ovf     <= ovf_next;
    nibble  <= nibble_next;
    last    <= last_next;
  end

  a_last_is_digit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (nibble <= 4'd9))
    else $error("final nibble is not a decimal digit");

  a_conv_runs: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV && bit_cnt != BIT_LAST) |=> (state == S_CONV))
    else $error("conversion left early");

  a_dig_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIG_HI || state == S_DIG_LO) |-> (dig_cnt != '0))
    else $error("digit count empty while printing");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == S_IDLE && !q_stat.empty))
    else $error("queue popped outside idle");

endmodule

// ===== hdl/signed_int_to_lcd_nibble_stream.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_lcd_nibble_stream
// Prints signed integers in decimal as ASCII characters, each sent as a high
// and a low nibble for a 4-bit character display bus.
//
//   Channel  Handshake            Payload
//   input    in_valid, in_ready   value
//   output   out_valid, out_ready nibble, last
//
// In the back end, an item passes through idle, the shift-and-add-three
// conversion, leading-zero skipping and a high and a low nibble for each
// character; the conversion, one input bit a cycle, takes most of the time.
// Reset clears the queue, the sequencer and the output valid.
// The queue holds two items, so input is taken while the back end works or
// while the output is stalled, until the queue is full.
// ----------------------------------------------------------------------------
module signed_int_to_lcd_nibble_stream #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [3:0]                   nibble,
  output logic                         last
);
  import silcd_pkg::*;

  q_stat_t               q_stat;
  logic                  push;
  logic                  push_neg;
  logic [VALUE_BITS-1:0] push_mag;
  logic                  pop;
  logic                  head_neg;
  logic [VALUE_BITS-1:0] head_mag;

  silcd_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .value    (value),
    .q_stat   (q_stat),
    .push     (push),
    .push_neg (push_neg),
    .push_mag (push_mag)
  );

  silcd_queue #(.VALUE_BITS(VALUE_BITS)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_neg (push_neg),
    .push_mag (push_mag),
    .pop      (pop),
    .q_stat   (q_stat),
    .head_neg (head_neg),
    .head_mag (head_mag)
  );

  silcd_back #(.VALUE_BITS(VALUE_BITS), .MAX_DIGITS(MAX_DIGITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head_neg  (head_neg),
    .head_mag  (head_mag),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .nibble    (nibble),
    .last      (last)
  );

endmodule

// ===== tb/tb_signed_int_to_lcd_nibble_stream.sv =====
// ----------------------------------------------------------------------------
// tb_signed_int_to_lcd_nibble_stream
// Self-checking bench for the signed integer to display nibble stream block.
// It computes the decimal text of each accepted integer, including the minus
// sign, the single zero and the most negative value, and checks every nibble
// and last flag in order. Both handshakes idle at random, except during one
// stretch of steady traffic.
// ----------------------------------------------------------------------------
module tb_signed_int_to_lcd_nibble_stream;
  timeunit 1ns;
  timeprecision 1ps;

  import silcd_pkg::*;

  localparam int VALUE_BITS = 32;
  localparam int MAX_DIGITS = 10;
  localparam int N_RANDOM   = 340;
  localparam int IDLE_PCT   = 37;

  typedef struct {
    logic [3:0] nib;
    logic       last;
  } nibble_word_t;

  class lcd_text_scoreboard;
    nibble_word_t pending_nibbles[$];
    int errors;
    int n_values;
    int n_negative;
    int n_nibbles;

    function new();
      errors = 0;
      n_values = 0;
      n_negative = 0;
      n_nibbles = 0;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    function void push_char(logic [7:0] ch, logic final_char);
      nibble_word_t w;
      w.nib = ch[7:4];
      w.last = 1'b0;
      pending_nibbles.push_back(w);
      w.nib = ch[3:0];
      w.last = final_char;
      pending_nibbles.push_back(w);
    endfunction

    function void note_value(logic signed [VALUE_BITS-1:0] v);
      logic [VALUE_BITS-1:0] mag;
      logic [3:0] digs[MAX_DIGITS];
      int nd;
      bit neg;
      neg = v[VALUE_BITS-1];
      mag = neg ? (~$unsigned(v) + 1'b1) : $unsigned(v);
      nd = 0;
      n_values++;
      if (neg) n_negative++;
      if (mag == 0) begin
        push_char(CHAR_ZERO, 1'b1);
        return;
      end
      while (mag != 0 && nd < MAX_DIGITS) begin
        digs[nd] = 4'(mag % 10);
        mag = mag / 10;
        nd++;
      end
      if (neg) push_char(CHAR_MINUS, 1'b0);
      for (int i = nd - 1; i >= 0; i--) begin
        push_char(CHAR_ZERO + 8'(digs[i]), i == 0);
      end
    endfunction

    task check_nibble(logic [3:0] nib, logic last);
      nibble_word_t w;
      n_nibbles++;
      if (pending_nibbles.size() == 0) begin
        report($sformatf("unexpected word nibble=%h last=%b", nib, last));
        return;
      end
      w = pending_nibbles.pop_front();
      if (nib !== w.nib) report($sformatf("nibble %h, expected %h", nib, w.nib));
      if (last !== w.last) report($sformatf("last %b, expected %b", last, w.last));
    endtask
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [VALUE_BITS-1:0] value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [3:0]                   nibble;
  logic                         last;

  bit calm = 1'b0;
  lcd_text_scoreboard sb = new();

  signed_int_to_lcd_nibble_stream #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .nibble(nibble),
    .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_nibble(nibble, last);
  end

  task automatic send_value(input logic signed [VALUE_BITS-1:0] v);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_value(v);
  endtask

  function automatic logic signed [VALUE_BITS-1:0] random_value();
    logic [VALUE_BITS-1:0] lim;
    logic [VALUE_BITS-1:0] mag;
    int k;
    case ($urandom_range(0, 3))
      0, 1: return $urandom;
      2: begin
        k = $urandom_range(1, 10);
        lim = 1;
        for (int i = 0; i < k && i < 9; i++) lim = lim * 10;
        if (k == 10) lim = 32'h7FFF_FFFF;
        else lim = lim - 1;
        mag = $urandom_range(0, lim);
        return $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
      end
      default: begin
        k = $urandom_range(0, 9);
        lim = 1;
        for (int i = 0; i < k; i++) lim = lim * 10;
        case ($urandom_range(0, 5))
          0: mag = lim;
          1: mag = lim - 1;
          2: mag = lim + 1;
          3: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
          4: return 32'sh8000_0000 + $urandom_range(0, 3);
          default: return $signed(32'hFFFF_FFFF - $urandom_range(0, 3));
        endcase
        return $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
      end
    endcase
  endfunction

  initial begin
    logic signed [VALUE_BITS-1:0] directed[$];
    directed = '{0, 1, -1, 9, -9, 10, -10, 99, -100, 12345, -67890,
                 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001,
                 1000000000, -999999999, 123456789, -1023456789,
                 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_value(directed[i]);
    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 140 && n < 220);
      send_value(random_value());
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    while (sb.pending_nibbles.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("Covered %0d integers (%0d negative), checked %0d nibble words.",
             sb.n_values, sb.n_negative, sb.n_nibbles);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d nibble words still pending.", sb.pending_nibbles.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
